[rtl/mlsp_pkg.sv]
package mlsp_pkg;

    localparam int MAX_LABELS_DEF = 8;
    localparam int CH_W           = 8;
    localparam int LABEL_W        = 20;
    localparam int ENTRY_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int CNT_W          = 7;
    localparam int DIGIT_W        = 5;

    localparam logic [LABEL_W-1:0] LABEL_MAX  = 20'hFFFFF;
    localparam logic [ENTRY_W-1:0] BOS_BIT    = 32'h0000_0100;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [CH_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_F   = 8'h46;
    localparam logic [CH_W-1:0] CH_LC_X   = 8'h78;
    localparam logic [CH_W-1:0] CH_UC_X   = 8'h58;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 5'd16;

    typedef enum logic [6:0] {
        PH_SKIP   = 7'b0000001,
        PH_START  = 7'b0000010,
        PH_SIGNED = 7'b0000100,
        PH_ZERO   = 7'b0001000,
        PH_HEXPFX = 7'b0010000,
        PH_DIGITS = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MALFORM  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_TOO_MANY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CT_IDLE = 3'b001,
        CT_READ = 3'b010,
        CT_LOAD = 3'b100
    } ctrl_t;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = DIGIT_W'(c - CH_ZERO);
        else if (c >= CH_LC_A && c <= CH_LC_F)
            d = DIGIT_W'(c - CH_LC_A + 8'd10);
        else if (c >= CH_UC_A && c <= CH_UC_F)
            d = DIGIT_W'(c - CH_UC_A + 8'd10);
        return d;
    endfunction

    function automatic logic [DIGIT_W-1:0] radix_base(input radix_t r);
        logic [DIGIT_W-1:0] b;
        case (r)
            RADIX_HEX: b = 5'd16;
            RADIX_OCT: b = 5'd8;
            default:   b = 5'd10;
        endcase
        return b;
    endfunction

endpackage

[rtl/mpls_label_stack_parser.sv]
// channel   | dir | tdata                          | tuser      | tlast
// s_axis    | in  | [7:0] ch                       | -          | end_of_text
// m_axis    | out | [31:0] entry, [38:32] count    | [1:0] status | last
//
// one text character per cycle while idle; after an end item each label entry
// is read from the label memory, then loaded into the output register
// an error run gives one result after the end item
// no new text is taken while a run is being emitted; a stalled output holds
// the emit loop, and characters keep flowing while the last result waits
// reset is asynchronous and leaves the parser in leading whitespace skip
module mpls_label_stack_parser #(
    parameter int MAX_LABELS = mlsp_pkg::MAX_LABELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] entry, [38:32] label_count, [39] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    localparam int AW    = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int CNT_W = mlsp_pkg::CNT_W;
    localparam int LW    = mlsp_pkg::LABEL_W;
    localparam int DW    = mlsp_pkg::DIGIT_W;
    localparam int PW    = LW + 5;

    mlsp_pkg::phase_t  phase_reg, phase_next;
    mlsp_pkg::radix_t  radix_reg, radix_next;
    mlsp_pkg::status_t err_reg, err_next;
    mlsp_pkg::ctrl_t   ctrl_reg, ctrl_next;
    logic [LW-1:0]     acc_reg, acc_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_entry_reg, out_entry_next;
    mlsp_pkg::status_t     out_status_reg, out_status_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_load;

    logic [LW-1:0] label_mem [MAX_LABELS];
    logic [LW-1:0] rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_data;
    logic          rd_en;

    logic              in_fire;
    logic              out_free;
    mlsp_pkg::phase_t  eff_phase;
    mlsp_pkg::radix_t  use_radix;
    logic [DW-1:0]     dig;
    logic [DW-1:0]     base;
    logic [PW-1:0]     acc_mul;
    logic [PW-1:0]     acc_sum;
    logic [LW-1:0]     acc_upd;
    logic              ovf_upd;
    logic [CNT_W-1:0]  count_inc;
    logic              store_ok;
    logic              end_lbl;
    logic              clear_run;
    logic              is_last;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (ctrl_reg == mlsp_pkg::CT_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // whitespace skip ends on the first other character, which is then a label start
    always_comb
    begin
        if (phase_reg == mlsp_pkg::PH_SKIP && !mlsp_pkg::is_space(s_axis_tdata))
            eff_phase = mlsp_pkg::PH_START;
        else
            eff_phase = phase_reg;
    end

    always_comb
    begin
        case (eff_phase)
            mlsp_pkg::PH_ZERO:   use_radix = mlsp_pkg::RADIX_OCT;
            mlsp_pkg::PH_HEXPFX: use_radix = mlsp_pkg::RADIX_HEX;
            mlsp_pkg::PH_DIGITS: use_radix = radix_reg;
            default:             use_radix = mlsp_pkg::RADIX_DEC;
        endcase
    end

    assign dig  = mlsp_pkg::digit_value(s_axis_tdata);
    assign base = mlsp_pkg::radix_base(use_radix);

    // multiply by the base with shifts, and a shift-and-add for decimal
    always_comb
    begin
        case (use_radix)
            mlsp_pkg::RADIX_HEX: acc_mul = {1'b0, acc_reg, 4'b0};
            mlsp_pkg::RADIX_OCT: acc_mul = {2'b0, acc_reg, 3'b0};
            default:             acc_mul = {2'b0, acc_reg, 3'b0} + {4'b0, acc_reg, 1'b0};
        endcase
        acc_sum = acc_mul + PW'(dig);
        if (ovf_reg || acc_sum > PW'(mlsp_pkg::LABEL_MAX))
        begin
            ovf_upd = 1'b1;
            acc_upd = mlsp_pkg::LABEL_MAX;
        end
        else
        begin
            ovf_upd = 1'b0;
            acc_upd = acc_sum[LW-1:0];
        end
    end

    assign count_inc = count_reg + CNT_W'(1);
    assign store_ok  = count_reg < CNT_W'(MAX_LABELS);
    assign is_last   = (idx_reg + CNT_W'(1)) == count_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        radix_next      = radix_reg;
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        ctrl_next       = ctrl_reg;
        idx_next        = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = acc_reg;
        rd_en           = 1'b0;
        end_lbl         = 1'b0;
        clear_run       = 1'b0;
        out_load        = 1'b0;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        if (in_fire && phase_reg != mlsp_pkg::PH_DONE)
        begin
            if (s_axis_tlast || s_axis_tdata == mlsp_pkg::CH_NUL)
            begin
                // text ends: keep the label in progress if it has digits and is in range
                phase_next = mlsp_pkg::PH_DONE;
                if (phase_reg == mlsp_pkg::PH_ZERO || phase_reg == mlsp_pkg::PH_DIGITS)
                begin
                    if (ovf_reg)
                        err_next = mlsp_pkg::ST_RANGE;
                    else
                    begin
                        wr_en      = store_ok;
                        count_next = count_inc;
                        err_next   = mlsp_pkg::ST_OK;
                    end
                end
                else
                    err_next = mlsp_pkg::ST_MALFORM;
            end
            else
            begin
                case (eff_phase)
                    mlsp_pkg::PH_SKIP:
                    begin
                        phase_next = mlsp_pkg::PH_SKIP;
                    end
                    mlsp_pkg::PH_START, mlsp_pkg::PH_SIGNED:
                    begin
                        if (eff_phase == mlsp_pkg::PH_START && s_axis_tdata == mlsp_pkg::CH_PLUS)
                            phase_next = mlsp_pkg::PH_SIGNED;
                        else if (s_axis_tdata == mlsp_pkg::CH_ZERO)
                            phase_next = mlsp_pkg::PH_ZERO;
                        else if (dig < DW'(10))
                        begin
                            radix_next = mlsp_pkg::RADIX_DEC;
                            acc_next   = acc_upd;
                            ovf_next   = ovf_upd;
                            phase_next = mlsp_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            err_next   = mlsp_pkg::ST_MALFORM;
                            phase_next = mlsp_pkg::PH_DONE;
                        end
                    end
                    mlsp_pkg::PH_ZERO:
                    begin
                        if (s_axis_tdata == mlsp_pkg::CH_LC_X || s_axis_tdata == mlsp_pkg::CH_UC_X)
                            phase_next = mlsp_pkg::PH_HEXPFX;
                        else if (dig < DW'(8))
                        begin
                            radix_next = mlsp_pkg::RADIX_OCT;
                            acc_next   = acc_upd;
                            ovf_next   = ovf_upd;
                            phase_next = mlsp_pkg::PH_DIGITS;
                        end
                        else
                            end_lbl = 1'b1;
                    end
                    mlsp_pkg::PH_HEXPFX:
                    begin
                        if (dig < DW'(16))
                        begin
                            radix_next = mlsp_pkg::RADIX_HEX;
                            acc_next   = acc_upd;
                            ovf_next   = ovf_upd;
                            phase_next = mlsp_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            err_next   = mlsp_pkg::ST_MALFORM;
                            phase_next = mlsp_pkg::PH_DONE;
                        end
                    end
                    mlsp_pkg::PH_DIGITS:
                    begin
                        if (dig < base)
                        begin
                            acc_next = acc_upd;
                            ovf_next = ovf_upd;
                        end
                        else
                            end_lbl = 1'b1;
                    end
                    default:
                    begin
                        err_next   = mlsp_pkg::ST_MALFORM;
                        phase_next = mlsp_pkg::PH_DONE;
                    end
                endcase

                // a character outside the digits closes the label
                if (end_lbl)
                begin
                    if (ovf_reg)
                    begin
                        err_next   = mlsp_pkg::ST_RANGE;
                        phase_next = mlsp_pkg::PH_DONE;
                    end
                    else if (s_axis_tdata != mlsp_pkg::CH_SLASH)
                    begin
                        err_next   = mlsp_pkg::ST_MALFORM;
                        phase_next = mlsp_pkg::PH_DONE;
                    end
                    else
                    begin
                        wr_en      = store_ok;
                        count_next = count_inc;
                        if (count_inc >= CNT_W'(MAX_LABELS))
                        begin
                            err_next   = mlsp_pkg::ST_TOO_MANY;
                            phase_next = mlsp_pkg::PH_DONE;
                        end
                        else
                        begin
                            radix_next = mlsp_pkg::RADIX_DEC;
                            acc_next   = '0;
                            ovf_next   = 1'b0;
                            phase_next = mlsp_pkg::PH_START;
                        end
                    end
                end
            end
        end

        case (ctrl_reg)
            mlsp_pkg::CT_IDLE:
            begin
                if (in_fire && s_axis_tlast)
                begin
                    ctrl_next = mlsp_pkg::CT_READ;
                    idx_next  = '0;
                end
            end
            mlsp_pkg::CT_READ:
            begin
                if (out_free)
                begin
                    if (err_reg != mlsp_pkg::ST_OK || count_reg == '0)
                    begin
                        out_load        = 1'b1;
                        out_entry_next  = '0;
                        out_status_next = (err_reg != mlsp_pkg::ST_OK) ? err_reg
                                                                       : mlsp_pkg::ST_MALFORM;
                        out_count_next  = '0;
                        out_last_next   = 1'b1;
                        clear_run       = 1'b1;
                        ctrl_next       = mlsp_pkg::CT_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        ctrl_next = mlsp_pkg::CT_LOAD;
                    end
                end
            end
            mlsp_pkg::CT_LOAD:
            begin
                // output register was free when the read went out
                out_load        = 1'b1;
                out_entry_next  = {rd_data_reg, 12'b0} | (is_last ? mlsp_pkg::BOS_BIT : '0);
                out_status_next = mlsp_pkg::ST_OK;
                out_count_next  = count_reg;
                out_last_next   = is_last;
                idx_next        = idx_reg + CNT_W'(1);
                if (is_last)
                begin
                    clear_run = 1'b1;
                    ctrl_next = mlsp_pkg::CT_IDLE;
                end
                else
                    ctrl_next = mlsp_pkg::CT_READ;
            end
            default:
            begin
                ctrl_next = mlsp_pkg::CT_IDLE;
            end
        endcase

        if (clear_run)
        begin
            phase_next = mlsp_pkg::PH_SKIP;
            radix_next = mlsp_pkg::RADIX_DEC;
            acc_next   = '0;
            ovf_next   = 1'b0;
            count_next = '0;
            err_next   = mlsp_pkg::ST_OK;
            idx_next   = '0;
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mlsp_pkg::PH_SKIP;
            radix_reg     <= mlsp_pkg::RADIX_DEC;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            err_reg       <= mlsp_pkg::ST_OK;
            ctrl_reg      <= mlsp_pkg::CT_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            radix_reg     <= radix_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            ctrl_reg      <= ctrl_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg  <= out_entry_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            label_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= label_mem[idx_reg[AW-1:0]];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg, out_entry_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LABELS))
        else $error("label count beyond store depth");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg == mlsp_pkg::CT_LOAD) |-> !out_valid_reg)
        else $error("entry load while output register busy");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != mlsp_pkg::ST_OK)
            |-> (out_count_reg == '0 && out_last_reg && out_entry_reg == '0))
        else $error("error result not a single empty final result");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg == mlsp_pkg::CT_LOAD && is_last) |=>
            (ctrl_reg == mlsp_pkg::CT_IDLE && phase_reg == mlsp_pkg::PH_SKIP
             && count_reg == '0))
        else $error("parser not cleared after last entry");

    a_read_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg == mlsp_pkg::CT_LOAD) |-> (idx_reg < count_reg))
        else $error("entry read past stored labels");
`endif

endmodule
